// File: hw/rtl/pdfw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdfw_pkg
// Shared types, register codes and colour expansion for the 2x pixel doubler
// framebuffer writer.
// ----------------------------------------------------------------------------
package pdfw_pkg;

  // default source raster
  localparam int SOURCE_WIDTH_DEF  = 320;
  localparam int SOURCE_HEIGHT_DEF = 240;

  localparam int FB_DIM_W  = 13;
  localparam int ADDR_W    = 26;
  localparam int WORD_W    = 32;
  localparam int PIX_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [FB_DIM_W-1:0] FB_WIDTH_RST  = 13'd640;
  localparam logic [FB_DIM_W-1:0] FB_HEIGHT_RST = 13'd480;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 2'd2;

  // depth codes; the fourth code is unsupported and behaves as off
  typedef enum logic [1:0] {
    DEPTH_16  = 2'd0,
    DEPTH_32  = 2'd1,
    DEPTH_OFF = 2'd2
  } depth_mode_t;

  // reciprocal constants for floor(n/31) and floor(n/63)
  localparam logic [13:0] RECIP_31   = 14'd8457;
  localparam int          RECIP_31_SH = 18;
  localparam logic [14:0] RECIP_63   = 15'd16645;
  localparam int          RECIP_63_SH = 20;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_rgb565;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [WORD_W-1:0] write_word;
    logic              last_of_block;
  } out_item_t;

  // one 2x2 block handed to the write sequencer
  typedef struct packed {
    logic [ADDR_W-1:0]   base;    // pixel index of the top-left write
    logic [FB_DIM_W-1:0] stride;  // pixels per framebuffer row
    logic [WORD_W-1:0]   word;
    logic                wide;    // 4 bytes per pixel
  } job_t;

  // RGB565 -> XRGB8888, each channel c*255/max floored
  function automatic logic [WORD_W-1:0] rgb565_to_xrgb(input logic [PIX_W-1:0] p);
    logic [12:0] rn;
    logic [12:0] bn;
    logic [13:0] gn;
    logic [26:0] rp;
    logic [26:0] bp;
    logic [28:0] gp;
    rn = 13'(p[15:11]) * 13'd255;
    bn = 13'(p[4:0]) * 13'd255;
    gn = 14'(p[10:5]) * 14'd255;
    rp = 27'(rn) * 27'(RECIP_31);
    bp = 27'(bn) * 27'(RECIP_31);
    gp = 29'(gn) * 29'(RECIP_63);
    return {8'h00, rp[RECIP_31_SH+7:RECIP_31_SH], gp[RECIP_63_SH+7:RECIP_63_SH],
            bp[RECIP_31_SH+7:RECIP_31_SH]};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pdfw_burst.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdfw_burst
// Write sequencer: turns one block job into four framebuffer writes through
// a registered output stage.
// ----------------------------------------------------------------------------
module pdfw_burst (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire pdfw_pkg::job_t     job,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pdfw_pkg::out_item_t     out_data
);
  import pdfw_pkg::*;

  localparam logic [1:0] QUAD_LAST = 2'd3;

  job_t              job_r;
  logic              busy_r;
  logic [1:0]        quad_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              emit;
  logic              last;
  logic [ADDR_W-1:0] pix_idx;
  logic [ADDR_W-1:0] addr;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign last      = (quad_r == QUAD_LAST);
  assign job_ready = !busy_r || (emit && last);

  // quad[1] selects the lower row, quad[0] the right column
  always_comb begin
    pix_idx = job_r.base + (quad_r[1] ? ADDR_W'(job_r.stride) : '0) + ADDR_W'(quad_r[0]);
    addr    = job_r.wide ? {pix_idx[ADDR_W-3:0], 2'b00} : {pix_idx[ADDR_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      quad_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy_r <= 1'b1;
        quad_r <= '0;
      end else if (emit) begin
        busy_r <= !last;
        quad_r <= quad_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (emit) begin
      out_item_r.byte_address  <= addr;
      out_item_r.write_word    <= job_r.word;
      out_item_r.last_of_block <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |=> busy_r && quad_r == '0)
    else $error("job taken but sequencer not restarted");

  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last |=> busy_r)
    else $error("burst ended before fourth write");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && out_item_r.last_of_block == ($past(quad_r) == QUAD_LAST))
    else $error("last_of_block out of step with write count");

endmodule
`default_nettype wire

// File: hw/rtl/pixel_doubler_fb_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_doubler_fb_writer
// 2x nearest-neighbour upscaler: RGB565 raster in, centred 2x2 framebuffer
// writes out, in 16 bpp or expanded XRGB8888.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order, SOURCE_WIDTH per row and SOURCE_HEIGHT
// rows per frame; frame_start on a request zeroes the column/row counters.
// A pixel inside the drawn window becomes four writes in the order top-left,
// top-right, bottom-left, bottom-right, the fourth flagged last_of_block. The
// window is min(fb_width, 2*SOURCE_WIDTH) by min(fb_height, 2*SOURCE_HEIGHT),
// centred in the framebuffer; byte_address = (row*fb_width + col) * bpp bytes,
// wrapped to 26 bits. Pixels outside the window, or with depth_mode off or
// unsupported, advance the position and produce nothing.
// A visible pixel occupies the single write port for its four writes;
// invisible pixels are taken at one per cycle whenever the input stage is
// free. A request passes through the input stage, the sequencer's job
// register and the output register before its first write; the block
// multiply between them is combinational. The output register lets the next
// pixel be taken while writes of the previous one are still waiting.
// Configuration writes take effect at once (cfg_ready is always high); change
// them only while the block is idle. Out-of-range register indexes are ignored.
// ----------------------------------------------------------------------------
module pixel_doubler_fb_writer #(
  parameter int SOURCE_WIDTH  = pdfw_pkg::SOURCE_WIDTH_DEF,
  parameter int SOURCE_HEIGHT = pdfw_pkg::SOURCE_HEIGHT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // source pixel requests
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire pdfw_pkg::in_item_t                   in_data,
  // framebuffer write requests
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output pdfw_pkg::out_item_t                       out_data,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pdfw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pdfw_pkg::FB_DIM_W-1:0]        cfg_data
);
  import pdfw_pkg::*;

  localparam int COL_W = (SOURCE_WIDTH  > 1) ? $clog2(SOURCE_WIDTH)  : 1;
  localparam int ROW_W = (SOURCE_HEIGHT > 1) ? $clog2(SOURCE_HEIGHT) : 1;
  localparam logic [COL_W-1:0]    COL_LAST = COL_W'(SOURCE_WIDTH - 1);
  localparam logic [ROW_W-1:0]    ROW_LAST = ROW_W'(SOURCE_HEIGHT - 1);
  // full doubled source size, the window's upper bound
  localparam logic [FB_DIM_W-1:0] DW_MAX   = FB_DIM_W'(2 * SOURCE_WIDTH);
  localparam logic [FB_DIM_W-1:0] DH_MAX   = FB_DIM_W'(2 * SOURCE_HEIGHT);

  // ---- configuration registers ----
  logic [FB_DIM_W-1:0] fb_width_r;
  logic [FB_DIM_W-1:0] fb_height_r;
  logic [1:0]          depth_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r   <= FB_WIDTH_RST;
      fb_height_r  <= FB_HEIGHT_RST;
      depth_mode_r <= DEPTH_OFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FB_WIDTH:   fb_width_r   <= cfg_data;
        REG_FB_HEIGHT:  fb_height_r  <= cfg_data;
        REG_DEPTH_MODE: depth_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---- position tracking and window test at the input ----
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_cur;
  logic [ROW_W-1:0]    row_cur;
  logic                in_fire;
  logic                enabled;
  logic                visible;
  logic [FB_DIM_W-1:0] ox;
  logic [FB_DIM_W-1:0] oy;
  logic [FB_DIM_W-1:0] col0_nxt;
  logic [FB_DIM_W-1:0] row0_nxt;
  logic [WORD_W-1:0]   word_nxt;

  // input stage
  logic                s1_valid_r;
  logic [FB_DIM_W-1:0] s1_col0_r;
  logic [FB_DIM_W-1:0] s1_row0_r;
  logic [WORD_W-1:0]   s1_word_r;
  logic                s1_wide_r;

  logic                job_ready;
  job_t                job;
  logic [ADDR_W-1:0]   row_base;

  assign in_ready = !s1_valid_r || job_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    enabled  = (depth_mode_r == DEPTH_16) || (depth_mode_r == DEPTH_32);
    // col < dw/2 reduces to col < fb_width/2 since col never reaches SOURCE_WIDTH
    visible  = enabled && ((FB_DIM_W-1)'(col_cur) < fb_width_r[FB_DIM_W-1:1])
                       && ((FB_DIM_W-1)'(row_cur) < fb_height_r[FB_DIM_W-1:1]);
    ox       = (fb_width_r  >= DW_MAX) ? (fb_width_r  - DW_MAX) >> 1 : '0;
    oy       = (fb_height_r >= DH_MAX) ? (fb_height_r - DH_MAX) >> 1 : '0;
    col0_nxt = ox + {(FB_DIM_W-1)'(col_cur), 1'b0};
    row0_nxt = oy + {(FB_DIM_W-1)'(row_cur), 1'b0};
    word_nxt = (depth_mode_r == DEPTH_16) ? WORD_W'(in_data.pixel_rgb565)
                                          : rgb565_to_xrgb(in_data.pixel_rgb565);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (col_cur == COL_LAST) begin
          col_r <= '0;
          row_r <= (row_cur == ROW_LAST) ? '0 : row_cur + ROW_W'(1);
        end else begin
          col_r <= col_cur + COL_W'(1);
          row_r <= row_cur;
        end
        s1_valid_r <= visible;
      end else if (job_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col0_r <= col0_nxt;
      s1_row0_r <= row0_nxt;
      s1_word_r <= word_nxt;
      s1_wide_r <= (depth_mode_r == DEPTH_32);
    end
  end

  // ---- block base: one 13x13 multiply per pixel ----
  assign row_base = ADDR_W'(s1_row0_r) * ADDR_W'(fb_width_r);

  always_comb begin
    job.base   = row_base + ADDR_W'(s1_col0_r);
    job.stride = fb_width_r;
    job.word   = s1_word_r;
    job.wide   = s1_wide_r;
  end

  pdfw_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (s1_valid_r),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST && row_r <= ROW_LAST)
    else $error("source position beyond raster");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.frame_start && col_r != COL_LAST |=>
      col_r == COL_W'($past(col_r) + COL_W'(1)) && row_r == $past(row_r))
    else $error("column counter did not advance");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !job_ready |=> s1_valid_r && $stable(s1_col0_r) && $stable(s1_word_r))
    else $error("pending block lost while sequencer busy");

endmodule
`default_nettype wire

// File: bench/pdfw_write_checker.sv
// ----------------------------------------------------------------------------
// pdfw_write_checker
// Follows the pixel, write and register channels of the pixel doubler, works
// out the 2x2 framebuffer writes each accepted pixel should cause and checks
// the block's writes against them in order.
// ----------------------------------------------------------------------------
module pdfw_write_checker #(
  parameter int SOURCE_WIDTH  = pdfw_pkg::SOURCE_WIDTH_DEF,
  parameter int SOURCE_HEIGHT = pdfw_pkg::SOURCE_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  pdfw_pkg::in_item_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  pdfw_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pdfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdfw_pkg::FB_DIM_W-1:0]     cfg_data,
  output int                                mismatch_count,
  output int                                writes_pending,
  output int                                pixels_accepted,
  output int                                visible_pixels,
  output int                                writes_checked
);
  import pdfw_pkg::*;

  localparam int MAX_REPORTS = 10;

  // register copies and raster position
  logic [FB_DIM_W-1:0] fb_w;
  logic [FB_DIM_W-1:0] fb_h;
  logic [1:0]          depth;
  int                  src_col;
  int                  src_row;

  out_item_t expected_writes[$];
  int        n_err;
  int        n_pix;
  int        n_vis;
  int        n_wr;

  // per-channel floor(c * 255 / max)
  function automatic logic [WORD_W-1:0] widen_rgb565(input logic [PIX_W-1:0] p);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = 32'(p[15:11]);
    g = 32'(p[10:5]);
    b = 32'(p[4:0]);
    r = r * 255 / 31;
    g = g * 255 / 63;
    b = b * 255 / 31;
    return {8'h00, r[7:0], g[7:0], b[7:0]};
  endfunction

  task automatic add_block_writes(input in_item_t px);
    logic [63:0] win_w;
    logic [63:0] win_h;
    logic [63:0] off_x;
    logic [63:0] off_y;
    logic [63:0] bpp;
    logic [63:0] fb_row;
    logic [63:0] fb_col;
    logic [63:0] addr;
    logic [WORD_W-1:0] word;
    out_item_t wr;
    if (px.frame_start) begin
      src_col = 0;
      src_row = 0;
    end
    win_w = 64'(fb_w);
    win_h = 64'(fb_h);
    if (win_w >= 64'(2 * SOURCE_WIDTH)) win_w = 64'(2 * SOURCE_WIDTH);
    if (win_h >= 64'(2 * SOURCE_HEIGHT)) win_h = 64'(2 * SOURCE_HEIGHT);
    off_x = (64'(fb_w) - win_w) >> 1;
    off_y = (64'(fb_h) - win_h) >> 1;
    if ((depth == DEPTH_16 || depth == DEPTH_32) &&
        64'(src_col) < win_w / 2 && 64'(src_row) < win_h / 2) begin
      n_vis++;
      bpp  = (depth == DEPTH_16) ? 64'd2 : 64'd4;
      word = (depth == DEPTH_16) ? {16'h0000, px.pixel_rgb565}
                                 : widen_rgb565(px.pixel_rgb565);
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          fb_row = off_y + 64'(2 * src_row + dy);
          fb_col = off_x + 64'(2 * src_col + dx);
          addr   = (fb_row * 64'(fb_w) + fb_col) * bpp;
          wr.byte_address  = addr[ADDR_W-1:0];
          wr.write_word    = word;
          wr.last_of_block = (dy == 1 && dx == 1);
          expected_writes.push_back(wr);
        end
      end
    end
    if (src_col + 1 >= SOURCE_WIDTH) begin
      src_col = 0;
      src_row = (src_row + 1 >= SOURCE_HEIGHT) ? 0 : src_row + 1;
    end else begin
      src_col++;
    end
  endtask

  task automatic report_write(input string why, input out_item_t want, input out_item_t got);
    n_err++;
    if (n_err <= MAX_REPORTS) begin
      $display("write check (%0t): %s: expected addr %h word %h last %b, got addr %h word %h last %b",
               $realtime, why, want.byte_address, want.write_word, want.last_of_block,
               got.byte_address, got.write_word, got.last_of_block);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fb_w    = FB_WIDTH_RST;
      fb_h    = FB_HEIGHT_RST;
      depth   = DEPTH_OFF;
      src_col = 0;
      src_row = 0;
      expected_writes.delete();
      n_err = 0;
      n_pix = 0;
      n_vis = 0;
      n_wr  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FB_WIDTH:   fb_w  = cfg_data;
          REG_FB_HEIGHT:  fb_h  = cfg_data;
          REG_DEPTH_MODE: depth = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        n_wr++;
        if (expected_writes.size() == 0) begin
          report_write("no write outstanding", '0, out_data);
        end else begin
          want = expected_writes.pop_front();
          if (want.byte_address !== out_data.byte_address ||
              want.write_word !== out_data.write_word ||
              want.last_of_block !== out_data.last_of_block) begin
            report_write("mismatch", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        n_pix++;
        add_block_writes(in_data);
      end
    end
    mismatch_count  <= n_err;
    writes_pending  <= expected_writes.size();
    pixels_accepted <= n_pix;
    visible_pixels  <= n_vis;
    writes_checked  <= n_wr;
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the 2x pixel doubler framebuffer writer: a directed pass over
// colour extremes, window edges and odd register values, a run across the end
// of a source row, then random windows and pixel runs under bursty input and
// stalled output.
// ----------------------------------------------------------------------------
module tb_top;
  import pdfw_pkg::*;

  localparam int CYCLE_LIMIT       = 3_000_000;
  localparam int SETTLE_CYCLES     = 8;    // longer than the pipe, catches stray writes
  localparam int HOLD_CYCLES       = 400;  // long receiver hold-off
  localparam int RANDOM_PIXEL_GOAL = 60;
  localparam int ROW_PIXELS        = SOURCE_WIDTH_DEF;

  // codes the package leaves unnamed
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam logic [1:0]           DEPTH_SPARE = 2'd3;
  localparam logic [FB_DIM_W-1:0]  DIM_MAX     = '1;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FB_DIM_W-1:0]  cfg_data  = '0;

  int mismatch_count;
  int writes_pending;
  int pixels_accepted;
  int visible_pixels;
  int writes_checked;

  int burst_left  = 0;  // requests left in the current input burst
  int hold_req    = 0;  // bumped by the stimulus to ask for a hold-off
  int settings    = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  pixel_doubler_fb_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pdfw_write_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .writes_pending  (writes_pending),
    .pixels_accepted (pixels_accepted),
    .visible_pixels  (visible_pixels),
    .writes_checked  (writes_checked)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered just after a rising edge and
  // return just after one, so every drive lands as a single NBA per step.
  // --------------------------------------------------------------------------

  // One pixel request. Bursts of random length with random gaps between;
  // roughly one burst in four follows on with no gap at all.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {pix, fs};
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly random colours, with black and white mixed in
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // A run of pixels; only the first may carry frame_start
  task automatic send_run(input int len, input logic fs);
    for (int i = 0; i < len; i++) send_pixel(pick_pixel(), (i == 0) ? fs : 1'b0);
  endtask

  // Stop offering, wait for every outstanding write, then let an invisible
  // pixel still in the pipe fall out before anything is reconfigured.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (writes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FB_DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [FB_DIM_W-1:0] w, input logic [FB_DIM_W-1:0] h,
                            input logic [1:0] d);
    drain();
    write_reg(REG_FB_WIDTH, w);
    write_reg(REG_FB_HEIGHT, h);
    write_reg(REG_DEPTH_MODE, FB_DIM_W'(d));
    settings++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns every so often, and serves a
  // long hold-off whenever the stimulus asks for one, counted here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_pattern_t pattern;
    int          pattern_left;
    int          holds_done;
    pattern      = RX_OPEN;
    pattern_left = 0;
    holds_done   = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 200);
      end
      pattern_left--;
      case (pattern)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Run limit: ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          p0;
    int          phase;
    int          n_seq;
    logic [FB_DIM_W-1:0] w;
    logic [FB_DIM_W-1:0] h;
    logic [1:0]  d;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the block is off: 640x480 but no writes.
    send_pixel('1, 1'b1);
    send_pixel('0, 1'b0);

    // Reset sizes kept, 16 bpp: colour extremes, one channel at a time.
    drain();
    write_reg(REG_DEPTH_MODE, FB_DIM_W'(DEPTH_16));
    settings++;
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b0);

    // Same colours through the XRGB8888 expansion, plus a mid grey.
    set_window(640, 480, DEPTH_32);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'h8410, 1'b0);

    // Oversized framebuffer: address runs past 26 bits and wraps.
    set_window(DIM_MAX, DIM_MAX, DEPTH_32);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h1234, 1'b0);

    // Zero-sized window either way: nothing drawn.
    set_window('0, 480, DEPTH_16);
    send_pixel(16'hABCD, 1'b1);
    set_window(640, '0, DEPTH_16);
    send_pixel(16'hABCD, 1'b1);

    // Unsupported depth code behaves as off.
    set_window(640, 480, DEPTH_SPARE);
    send_pixel(16'h5555, 1'b1);

    // Write to a non-existent register must leave the window alone.
    set_window(640, 480, DEPTH_16);
    write_reg(REG_SPARE, DIM_MAX);
    send_pixel(16'hAAAA, 1'b1);

    // 1x1 has no visible source pixel; 2x2 shows column 0 only.
    set_window(1, 1, DEPTH_16);
    send_pixel(16'h1111, 1'b1);
    set_window(2, 2, DEPTH_32);
    send_pixel(16'h2222, 1'b1);
    send_pixel(16'h3333, 1'b0);

    // Odd sizes: centring offset rounds down.
    set_window(641, 481, DEPTH_16);
    send_pixel(16'h4444, 1'b1);

    // Row soak with a 4x4 framebuffer: one frame_start, then past the end of
    // source row 0 so the column wraps and row 1 shows again.
    set_window(4, 4, DEPTH_16);
    send_run(ROW_PIXELS + 4, 1'b1);

    // Random windows until enough further pixels have gone through.
    p0    = pixels_accepted;
    phase = 0;
    while (phase < 2 || pixels_accepted - p0 < RANDOM_PIXEL_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w = FB_DIM_W'($urandom_range(2, 24));
        6, 7:             w = FB_DIM_W'($urandom_range(600, 700));
        8:                w = FB_DIM_W'($urandom_range(1, 8191));
        default:          w = 640;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: h = FB_DIM_W'($urandom_range(2, 24));
        6, 7:             h = FB_DIM_W'($urandom_range(470, 500));
        8:                h = FB_DIM_W'($urandom_range(1, 8191));
        default:          h = 480;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3:    d = DEPTH_16;
        4, 5, 6, 7:    d = DEPTH_32;
        8:             d = DEPTH_OFF;
        default:       d = DEPTH_SPARE;
      endcase
      // Second phase: full window with the receiver held off, so the block
      // backs up and pushes back on the pixel requests.
      if (phase == 1) begin
        w = 640;
        h = 480;
        d = DEPTH_32;
      end
      set_window(w, h, d);
      if (phase == 1) hold_req++;

      n_seq = $urandom_range(2, 5);
      repeat (n_seq) begin
        case ($urandom_range(0, 19))
          // new frame then a short run along row 0
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
            send_run($urandom_range(1, 16), 1'b1);
          // longer run carrying on from the current position
          14, 15, 16:
            send_run($urandom_range(17, 40), 1'b0);
          // noise: frame_start dropped in at random
          default:
            repeat ($urandom_range(1, 10)) send_pixel(pick_pixel(), $urandom_range(0, 2) == 0);
        endcase
        // occasionally pause until every write is back
        if ($urandom_range(0, 7) == 0) drain();
      end
      phase++;
    end

    drain();
    $display("Ran %0d window settings: %0d pixels taken, %0d inside the window, %0d writes checked.",
             settings, pixels_accepted, visible_pixels, writes_checked);
    if (mismatch_count == 0 && writes_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pdfw_pkg.sv
hw/rtl/pdfw_burst.sv
hw/rtl/pixel_doubler_fb_writer.sv
bench/pdfw_write_checker.sv
bench/tb_top.sv
